@@ src/spp_pkg.sv @@
// ----------------------------------------------------------------------------
// spp_pkg
// Types and constants shared by the shadowed pixel plotter modules.
// ----------------------------------------------------------------------------
package spp_pkg;

    // Pixel operation codes.
    localparam logic [1:0] FUNC_CLEAR  = 2'd0;
    localparam logic [1:0] FUNC_SET    = 2'd1;
    localparam logic [1:0] FUNC_TOGGLE = 2'd2;
    localparam logic [1:0] FUNC_KEEP   = 2'd3;

    // Controller command bytes.
    localparam logic [7:0] CMD_EXTENDED = 8'h34;
    localparam logic [7:0] CMD_GFX_ON   = 8'h36;
    localparam logic [7:0] CMD_BASIC    = 8'h30;

    // Position of each byte in the seven-byte sequence.
    localparam logic [2:0] BYTE_EXT     = 3'd0;
    localparam logic [2:0] BYTE_ROW     = 3'd1;
    localparam logic [2:0] BYTE_COL     = 3'd2;
    localparam logic [2:0] BYTE_DATA_HI = 3'd3;
    localparam logic [2:0] BYTE_DATA_LO = 3'd4;
    localparam logic [2:0] BYTE_GFX_ON  = 3'd5;
    localparam logic [2:0] BYTE_BASIC   = 3'd6;

    // Shadow memory geometry: 32 rows of 16 word columns.
    localparam int SHADOW_AW    = 9;
    localparam int SHADOW_DEPTH = 512;

    // Job queue between front and back.
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = 1;

    typedef struct packed {
        logic [6:0] x_pos;
        logic [5:0] y_pos;
        logic [1:0] func;
    } pixel_in_t;

    typedef struct packed {
        logic       is_data;
        logic [7:0] byte_value;
        logic       last;
    } pixel_out_t;

    // A classified item: the shadow word address and the bit to change.
    typedef struct packed {
        logic [4:0] row;
        logic [3:0] col;
        logic [3:0] bit_sel;
        logic [1:0] func;
    } job_t;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_EMIT
    } back_state_t;

endpackage

@@ src/shadowed_pixel_plotter.sv @@
// ----------------------------------------------------------------------------
// shadowed_pixel_plotter
// Sets, clears or toggles one pixel in a 512-word shadow of graphics RAM
// and produces the seven controller bytes that write the word to the panel.
//
//   channel  | handshake          | payload
//   ---------+--------------------+-------------------------------------
//   input    | push / full        | pixel     (x_pos, y_pos, func)
//   result   | pop / empty        | ctrl_byte (is_data, byte_value, last)
//
// In the back end each item takes a shadow memory read, a write-back, and
// seven bytes through the output register, one per cycle when results are
// popped freely.
// After reset a clearing pass zeroes all 512 words of the shadow memory,
// one word per cycle; full stays high during it.
// A two-entry job queue lets the input side take items while the back end
// waits on pop.
// ----------------------------------------------------------------------------
module shadowed_pixel_plotter (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  spp_pkg::pixel_in_t  pixel,
    output logic                empty,
    input  logic                pop,
    output spp_pkg::pixel_out_t ctrl_byte
);
    import spp_pkg::*;

    logic q_full;
    logic q_empty;
    logic q_push;
    logic q_pop;
    logic clearing;
    job_t push_job;
    job_t head_job;

    spp_front u_front (
        .push     (push),
        .full     (full),
        .pixel    (pixel),
        .q_full   (q_full),
        .clearing (clearing),
        .q_push   (q_push),
        .q_job    (push_job)
    );

    spp_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_push),
        .wr_job  (push_job),
        .rd_en   (q_pop),
        .rd_job  (head_job),
        .q_full  (q_full),
        .q_empty (q_empty)
    );

    spp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_job     (head_job),
        .q_pop     (q_pop),
        .clearing  (clearing),
        .empty     (empty),
        .pop       (pop),
        .ctrl_byte (ctrl_byte)
    );

endmodule

@@ src/spp_front.sv @@
// ----------------------------------------------------------------------------
// spp_front
// Accepts pixel items and maps each to a shadow word address and bit.
// ----------------------------------------------------------------------------
module spp_front (
    input  logic              push,
    output logic              full,
    input  spp_pkg::pixel_in_t pixel,
    input  logic              q_full,
    input  logic              clearing,
    output logic              q_push,
    output spp_pkg::job_t     q_job
);
    import spp_pkg::*;

    assign full   = q_full | clearing;
    assign q_push = push & ~full;

    // Rows 32 to 63 fold onto rows 0 to 31 in the right half of the word columns.
    always_comb
    begin
        q_job.row     = pixel.y_pos[4:0];
        q_job.col     = {pixel.y_pos[5], pixel.x_pos[6:4]};
        q_job.bit_sel = pixel.x_pos[3:0];
        q_job.func    = pixel.func;
    end

endmodule

@@ src/spp_queue.sv @@
// ----------------------------------------------------------------------------
// spp_queue
// Short first-in first-out queue of classified jobs between front and back.
// ----------------------------------------------------------------------------
module spp_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_en,
    input  spp_pkg::job_t wr_job,
    input  logic          rd_en,
    output spp_pkg::job_t rd_job,
    output logic          q_full,
    output logic          q_empty
);
    import spp_pkg::*;

    job_t                entry_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg;
    logic [QUEUE_AW-1:0] wr_ptr_next;
    logic [QUEUE_AW-1:0] rd_ptr_reg;
    logic [QUEUE_AW-1:0] rd_ptr_next;
    logic [QUEUE_AW:0]   count_reg;
    logic [QUEUE_AW:0]   count_next;
    logic                do_wr;
    logic                do_rd;

    assign q_full  = (count_reg == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign q_empty = (count_reg == '0);
    assign rd_job  = entry_reg[rd_ptr_reg];
    assign do_wr   = wr_en & ~q_full;
    assign do_rd   = rd_en & ~q_empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0
                                                                      : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0
                                                                      : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            entry_reg[wr_ptr_reg] <= wr_job;
        end
    end

endmodule

@@ src/spp_back.sv @@
// ----------------------------------------------------------------------------
// spp_back
// Holds the shadow memory, updates one word per job and sends the seven
// controller bytes through an output register.
// ----------------------------------------------------------------------------
module spp_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_empty,
    input  spp_pkg::job_t       q_job,
    output logic                q_pop,
    output logic                clearing,
    output logic                empty,
    input  logic                pop,
    output spp_pkg::pixel_out_t ctrl_byte
);
    import spp_pkg::*;

    logic [15:0]          shadow_mem [SHADOW_DEPTH];
    logic [15:0]          rd_data_reg;

    back_state_t          state_reg;
    back_state_t          state_next;
    logic [SHADOW_AW-1:0] clr_idx_reg;
    logic [SHADOW_AW-1:0] clr_idx_next;
    job_t                 job_reg;
    job_t                 job_next;
    logic [15:0]          word_reg;
    logic [15:0]          word_next;
    logic [2:0]           cnt_reg;
    logic [2:0]           cnt_next;
    pixel_out_t           out_reg;
    pixel_out_t           out_next;
    logic                 out_valid_reg;
    logic                 out_valid_next;

    logic                 mem_we;
    logic [SHADOW_AW-1:0] mem_waddr;
    logic [15:0]          mem_wdata;
    logic                 mem_re;
    logic                 out_free;
    logic                 out_load;
    logic [15:0]          bit_mask;
    logic [15:0]          word_new;
    pixel_out_t           byte_sel;

    assign empty     = ~out_valid_reg;
    assign ctrl_byte = out_reg;
    assign out_free  = ~out_valid_reg | pop;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
            begin
                if (clr_idx_reg == '1)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (!q_empty)
                begin
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (out_free && cnt_reg == BYTE_BASIC)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    // Outputs of the state machine.
    always_comb
    begin
        clearing  = 1'b0;
        q_pop     = 1'b0;
        mem_re    = 1'b0;
        mem_we    = 1'b0;
        mem_waddr = {job_reg.row, job_reg.col};
        mem_wdata = word_new;
        out_load  = 1'b0;
        case (state_reg)
            S_CLEAR:
            begin
                clearing  = 1'b1;
                mem_we    = 1'b1;
                mem_waddr = clr_idx_reg;
                mem_wdata = '0;
            end
            S_IDLE:
            begin
                q_pop  = ~q_empty;
                mem_re = ~q_empty;
            end
            S_READ:
            begin
                mem_we = 1'b1;
            end
            S_EMIT:
            begin
                out_load = out_free;
            end
            default:
            begin
                clearing = 1'b0;
            end
        endcase
    end

    // Read-modify-write of the addressed shadow word.
    always_comb
    begin
        bit_mask = 16'h8000 >> job_reg.bit_sel;
        case (job_reg.func)
            FUNC_CLEAR:  word_new = rd_data_reg & ~bit_mask;
            FUNC_SET:    word_new = rd_data_reg | bit_mask;
            FUNC_TOGGLE: word_new = rd_data_reg ^ bit_mask;
            FUNC_KEEP:   word_new = rd_data_reg;
            default:     word_new = rd_data_reg;
        endcase
    end

    always_comb
    begin
        byte_sel.is_data    = 1'b0;
        byte_sel.last       = 1'b0;
        byte_sel.byte_value = CMD_EXTENDED;
        case (cnt_reg)
            BYTE_EXT:     byte_sel.byte_value = CMD_EXTENDED;
            BYTE_ROW:     byte_sel.byte_value = {3'b100, job_reg.row};
            BYTE_COL:     byte_sel.byte_value = {4'b1000, job_reg.col};
            BYTE_DATA_HI:
            begin
                byte_sel.is_data    = 1'b1;
                byte_sel.byte_value = word_reg[15:8];
            end
            BYTE_DATA_LO:
            begin
                byte_sel.is_data    = 1'b1;
                byte_sel.byte_value = word_reg[7:0];
            end
            BYTE_GFX_ON:  byte_sel.byte_value = CMD_GFX_ON;
            BYTE_BASIC:
            begin
                byte_sel.byte_value = CMD_BASIC;
                byte_sel.last       = 1'b1;
            end
            default:      byte_sel.byte_value = CMD_EXTENDED;
        endcase
    end

    always_comb
    begin
        clr_idx_next   = clr_idx_reg;
        job_next       = job_reg;
        word_next      = word_reg;
        cnt_next       = cnt_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        if (state_reg == S_CLEAR)
        begin
            clr_idx_next = clr_idx_reg + 1'b1;
        end
        if (q_pop)
        begin
            job_next = q_job;
        end
        if (state_reg == S_READ)
        begin
            word_next = word_new;
            cnt_next  = BYTE_EXT;
        end
        if (pop && out_valid_reg)
        begin
            out_valid_next = 1'b0;
        end
        if (out_load)
        begin
            out_next       = byte_sel;
            out_valid_next = 1'b1;
            cnt_next       = cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_idx_reg   <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_idx_reg   <= clr_idx_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg  <= job_next;
        word_reg <= word_next;
        out_reg  <= out_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            shadow_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= shadow_mem[{q_job.row, q_job.col}];
        end
    end

endmodule
